// ----- rtl/core/mqspm_pkg.sv -----
// shared constants, codes and memory word types for the slot pool manager
`default_nettype none

package mqspm_pkg;

  localparam int SLOTS  = 256;
  localparam int QUEUES = 32;

  localparam int SW     = $clog2(SLOTS);
  localparam int QW     = (QUEUES > 1) ? $clog2(QUEUES) : 1;
  localparam int LW     = SW + 1;
  localparam int CLR_N  = (SLOTS > QUEUES) ? SLOTS : QUEUES;
  localparam int CW     = $clog2(CLR_N);

  localparam int IN_SW  = 8;
  localparam int IN_QW  = 5;
  localparam int OUT_SW = 8;

  localparam logic [LW-1:0] NIL = LW'(SLOTS);

  typedef enum logic [1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_COMMIT = 2'd1,
    CMD_PEEK   = 2'd2,
    CMD_FREE   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_NOFREE  = 2'd1,
    STS_QEMPTY  = 2'd2,
    STS_BADSLOT = 2'd3
  } status_e;

  typedef struct packed {
    logic [QW-1:0] qid;
    logic          cmt;
    logic          alc;
  } owner_t;

  typedef struct packed {
    owner_t        own;
    logic [LW-1:0] qnext;
    logic [LW-1:0] qprev;
    logic [LW-1:0] gprev;
    logic [LW-1:0] gnext;
  } slot_ent_t;

  typedef struct packed {
    logic own;
    logic qn;
    logic qp;
    logic gp;
    logic gn;
  } slot_msk_t;

  typedef struct packed {
    logic [LW-1:0] head;
    logic [LW-1:0] tail;
  } qend_t;

endpackage

`default_nettype wire

// ----- rtl/core/multi_queue_slot_pool_manager_core.sv -----
// slot pool manager: free list, global allocation list and per-queue lists
// allocate and commit: evaluate, then a link write when the list was not empty; peek: evaluate
// free: evaluate, queue ends and both queue neighbours (committed only), global next neighbour, self write
// a new word is taken only in idle; busy_o holds while link updates go
// through the one slot memory write port, one per cycle; results cannot be stalled
// reset: a clearing pass over max(SLOTS, QUEUES) entries runs with busy_o high
`default_nettype none

module multi_queue_slot_pool_manager_core (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic [1:0]                   cmd_i,
  input  wire logic [mqspm_pkg::IN_SW-1:0]  slot_index_i,
  input  wire logic [mqspm_pkg::IN_QW-1:0]  queue_index_i,
  output logic                              done_o,
  output logic [1:0]                        status_o,
  output logic [mqspm_pkg::OUT_SW-1:0]      result_slot_o,
  output logic                              oldest_valid_o,
  output logic [mqspm_pkg::OUT_SW-1:0]      oldest_slot_o
);

  localparam logic [2:0] ST_INIT  = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_EVAL  = 3'd2;
  localparam logic [2:0] ST_QRD   = 3'd3;
  localparam logic [2:0] ST_LINK  = 3'd4;
  localparam logic [2:0] ST_FQP   = 3'd5;
  localparam logic [2:0] ST_FGP   = 3'd6;
  localparam logic [2:0] ST_FSELF = 3'd7;

  localparam int SW     = mqspm_pkg::SW;
  localparam int QW     = mqspm_pkg::QW;
  localparam int LW     = mqspm_pkg::LW;
  localparam int CW     = mqspm_pkg::CW;
  localparam int OUT_SW = mqspm_pkg::OUT_SW;

  // memories
  mqspm_pkg::slot_ent_t slot_mem [mqspm_pkg::SLOTS];
  mqspm_pkg::qend_t     qend_mem [mqspm_pkg::QUEUES];

  logic [SW-1:0]          sm_ra;
  logic                   sm_we;
  logic [SW-1:0]          sm_wa;
  mqspm_pkg::slot_ent_t   sm_wd;
  mqspm_pkg::slot_msk_t   sm_wm;
  mqspm_pkg::slot_ent_t   sm_rd_q;

  logic [QW-1:0]          qm_ra;
  logic                   qm_we;
  logic [QW-1:0]          qm_wa;
  mqspm_pkg::qend_t       qm_wd;
  mqspm_pkg::qend_t       qm_rd_q;

  // control and working registers
  logic [2:0]             state_q, state_d;
  mqspm_pkg::cmd_e        op_q, op_d;
  logic [SW-1:0]          slot_q, slot_d;
  logic [QW-1:0]          qid_q, qid_d;
  logic                   sok_q, sok_d;
  logic                   qok_q, qok_d;
  mqspm_pkg::slot_ent_t   ent_q, ent_d;
  logic [LW-1:0]          lk_q, lk_d;
  mqspm_pkg::status_e     sts_q, sts_d;
  logic [OUT_SW-1:0]      res_q, res_d;
  logic [LW-1:0]          free_top_q, free_top_d;
  logic [LW-1:0]          ghead_q, ghead_d;
  logic [LW-1:0]          gtail_q, gtail_d;
  logic [CW-1:0]          clr_q, clr_d;
  logic                   fin;

  // output word
  logic                   done_q;
  mqspm_pkg::status_e     out_sts_q;
  logic [OUT_SW-1:0]      out_res_q;
  logic                   out_ov_q;
  logic [OUT_SW-1:0]      out_os_q;

  always_ff @(posedge clk_i) begin
    if (sm_we) begin
      if (sm_wm.own) slot_mem[sm_wa].own   <= sm_wd.own;
      if (sm_wm.qn)  slot_mem[sm_wa].qnext <= sm_wd.qnext;
      if (sm_wm.qp)  slot_mem[sm_wa].qprev <= sm_wd.qprev;
      if (sm_wm.gp)  slot_mem[sm_wa].gprev <= sm_wd.gprev;
      if (sm_wm.gn)  slot_mem[sm_wa].gnext <= sm_wd.gnext;
    end
    sm_rd_q <= slot_mem[sm_ra];
  end

  always_ff @(posedge clk_i) begin
    if (qm_we) begin
      qend_mem[qm_wa] <= qm_wd;
    end
    qm_rd_q <= qend_mem[qm_ra];
  end

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    slot_d     = slot_q;
    qid_d      = qid_q;
    sok_d      = sok_q;
    qok_d      = qok_q;
    ent_d      = ent_q;
    lk_d       = lk_q;
    sts_d      = sts_q;
    res_d      = res_q;
    free_top_d = free_top_q;
    ghead_d    = ghead_q;
    gtail_d    = gtail_q;
    clr_d      = clr_q;
    fin        = 1'b0;
    sm_ra      = slot_q;
    sm_we      = 1'b0;
    sm_wa      = slot_q;
    sm_wd      = '0;
    sm_wm      = '0;
    qm_ra      = qid_q;
    qm_we      = 1'b0;
    qm_wa      = qid_q;
    qm_wd      = '0;

    case (state_q)
      ST_INIT: begin
        // clearing pass, free chain i -> i-1
        if (32'(clr_q) < mqspm_pkg::SLOTS) begin
          sm_we          = 1'b1;
          sm_wa          = SW'(clr_q);
          sm_wm          = '1;
          sm_wd.qnext    = mqspm_pkg::NIL;
          sm_wd.qprev    = mqspm_pkg::NIL;
          sm_wd.gprev    = mqspm_pkg::NIL;
          sm_wd.gnext    = (clr_q == '0) ? mqspm_pkg::NIL : LW'(clr_q - CW'(1));
        end
        if (32'(clr_q) < mqspm_pkg::QUEUES) begin
          qm_we      = 1'b1;
          qm_wa      = QW'(clr_q);
          qm_wd.head = mqspm_pkg::NIL;
          qm_wd.tail = mqspm_pkg::NIL;
        end
        clr_d = clr_q + CW'(1);
        if (clr_q == CW'(mqspm_pkg::CLR_N - 1)) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        qm_ra = QW'(queue_index_i);
        if (cmd_i == mqspm_pkg::CMD_ALLOC) begin
          sm_ra = free_top_q[SW-1:0];
        end else begin
          sm_ra = SW'(slot_index_i);
        end
        if (start_i) begin
          op_d    = mqspm_pkg::cmd_e'(cmd_i);
          slot_d  = sm_ra;
          qid_d   = QW'(queue_index_i);
          sok_d   = (32'(slot_index_i) < mqspm_pkg::SLOTS);
          qok_d   = (32'(queue_index_i) < mqspm_pkg::QUEUES);
          sts_d   = mqspm_pkg::STS_OK;
          res_d   = '0;
          state_d = ST_EVAL;
        end
      end

      ST_EVAL: begin
        case (op_q)
          mqspm_pkg::CMD_ALLOC: begin
            if (free_top_q == mqspm_pkg::NIL) begin
              sts_d = mqspm_pkg::STS_NOFREE;
              fin   = 1'b1;
            end else begin
              free_top_d        = sm_rd_q.gnext;
              sm_we             = 1'b1;
              sm_wm             = '1;
              sm_wd.own.alc     = 1'b1;
              sm_wd.qnext       = mqspm_pkg::NIL;
              sm_wd.qprev       = mqspm_pkg::NIL;
              sm_wd.gprev       = mqspm_pkg::NIL;
              sm_wd.gnext       = ghead_q;
              ghead_d           = LW'(slot_q);
              if (gtail_q == mqspm_pkg::NIL) begin
                gtail_d = LW'(slot_q);
              end
              res_d = OUT_SW'(slot_q);
              if (ghead_q != mqspm_pkg::NIL) begin
                lk_d    = ghead_q;
                state_d = ST_LINK;
              end else begin
                fin = 1'b1;
              end
            end
          end
          mqspm_pkg::CMD_COMMIT: begin
            if (!sok_q || !qok_q || !sm_rd_q.own.alc || sm_rd_q.own.cmt) begin
              sts_d = mqspm_pkg::STS_BADSLOT;
              fin   = 1'b1;
            end else begin
              sm_we         = 1'b1;
              sm_wm.own     = 1'b1;
              sm_wm.qn      = 1'b1;
              sm_wm.qp      = 1'b1;
              sm_wd.own.qid = qid_q;
              sm_wd.own.cmt = 1'b1;
              sm_wd.own.alc = 1'b1;
              sm_wd.qnext   = qm_rd_q.head;
              sm_wd.qprev   = mqspm_pkg::NIL;
              qm_we         = 1'b1;
              qm_wd.head    = LW'(slot_q);
              qm_wd.tail    = (qm_rd_q.tail == mqspm_pkg::NIL) ? LW'(slot_q) : qm_rd_q.tail;
              if (qm_rd_q.head != mqspm_pkg::NIL) begin
                lk_d    = qm_rd_q.head;
                state_d = ST_LINK;
              end else begin
                fin = 1'b1;
              end
            end
          end
          mqspm_pkg::CMD_PEEK: begin
            if (!qok_q || qm_rd_q.tail == mqspm_pkg::NIL) begin
              sts_d = mqspm_pkg::STS_QEMPTY;
            end else begin
              res_d = OUT_SW'(qm_rd_q.tail[SW-1:0]);
            end
            fin = 1'b1;
          end
          mqspm_pkg::CMD_FREE: begin
            if (!sok_q || !sm_rd_q.own.alc) begin
              sts_d = mqspm_pkg::STS_BADSLOT;
              fin   = 1'b1;
            end else begin
              ent_d = sm_rd_q;
              // unlink from the global list, previous side
              sm_we       = (sm_rd_q.gprev != mqspm_pkg::NIL);
              sm_wa       = sm_rd_q.gprev[SW-1:0];
              sm_wm.gn    = 1'b1;
              sm_wd.gnext = sm_rd_q.gnext;
              if (ghead_q == LW'(slot_q)) begin
                ghead_d = sm_rd_q.gnext;
              end
              if (gtail_q == LW'(slot_q)) begin
                gtail_d = sm_rd_q.gprev;
              end
              qm_ra   = sm_rd_q.own.qid;
              state_d = sm_rd_q.own.cmt ? ST_QRD : ST_FGP;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end

      ST_QRD: begin
        qm_we       = 1'b1;
        qm_wa       = ent_q.own.qid;
        qm_wd.head  = (qm_rd_q.head == LW'(slot_q)) ? ent_q.qnext : qm_rd_q.head;
        qm_wd.tail  = (qm_rd_q.tail == LW'(slot_q)) ? ent_q.qprev : qm_rd_q.tail;
        sm_we       = (ent_q.qprev != mqspm_pkg::NIL);
        sm_wa       = ent_q.qprev[SW-1:0];
        sm_wm.qn    = 1'b1;
        sm_wd.qnext = ent_q.qnext;
        state_d     = ST_FQP;
      end

      ST_FQP: begin
        sm_we       = (ent_q.qnext != mqspm_pkg::NIL);
        sm_wa       = ent_q.qnext[SW-1:0];
        sm_wm.qp    = 1'b1;
        sm_wd.qprev = ent_q.qprev;
        state_d     = ST_FGP;
      end

      ST_FGP: begin
        sm_we       = (ent_q.gnext != mqspm_pkg::NIL);
        sm_wa       = ent_q.gnext[SW-1:0];
        sm_wm.gp    = 1'b1;
        sm_wd.gprev = ent_q.gprev;
        state_d     = ST_FSELF;
      end

      ST_FSELF: begin
        sm_we       = 1'b1;
        sm_wm       = '1;
        sm_wd.qnext = mqspm_pkg::NIL;
        sm_wd.qprev = mqspm_pkg::NIL;
        sm_wd.gprev = mqspm_pkg::NIL;
        sm_wd.gnext = free_top_q;
        free_top_d  = LW'(slot_q);
        fin         = 1'b1;
      end

      ST_LINK: begin
        sm_we = 1'b1;
        sm_wa = lk_q[SW-1:0];
        if (op_q == mqspm_pkg::CMD_ALLOC) begin
          sm_wm.gp    = 1'b1;
          sm_wd.gprev = LW'(slot_q);
        end else begin
          sm_wm.qp    = 1'b1;
          sm_wd.qprev = LW'(slot_q);
        end
        fin = 1'b1;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (fin) begin
      state_d = ST_IDLE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_INIT;
      clr_q      <= '0;
      free_top_q <= LW'(mqspm_pkg::SLOTS - 1);
      ghead_q    <= mqspm_pkg::NIL;
      gtail_q    <= mqspm_pkg::NIL;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      free_top_q <= free_top_d;
      ghead_q    <= ghead_d;
      gtail_q    <= gtail_d;
      done_q     <= fin;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    slot_q <= slot_d;
    qid_q  <= qid_d;
    sok_q  <= sok_d;
    qok_q  <= qok_d;
    ent_q  <= ent_d;
    lk_q   <= lk_d;
    sts_q  <= sts_d;
    res_q  <= res_d;
    if (fin) begin
      out_sts_q <= sts_d;
      out_res_q <= res_d;
      out_ov_q  <= (gtail_d != mqspm_pkg::NIL);
      out_os_q  <= (gtail_d != mqspm_pkg::NIL) ? OUT_SW'(gtail_d[SW-1:0]) : '0;
    end
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign status_o       = out_sts_q;
  assign result_slot_o  = out_res_q;
  assign oldest_valid_o = out_ov_q;
  assign oldest_slot_o  = out_os_q;

  // checks
  a_accept_eval: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> state_q == ST_EVAL)
    else $error("accepted command did not enter evaluation");

  a_free_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_FSELF |=> done_o && !busy_o)
    else $error("free did not complete after self write");

  a_nofree_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o == mqspm_pkg::STS_NOFREE |-> oldest_valid_o)
    else $error("pool reported empty with no slot allocated");

  a_err_res_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && status_o != mqspm_pkg::STS_OK |-> result_slot_o == '0)
    else $error("error word carries a nonzero slot");

endmodule

`default_nettype wire

// ----- sim/tb.sv -----
// testbench for the slot pool manager core: directed, exhaustion and random commands
`timescale 1ns / 1ps

module tb;

  localparam int CYCLE_LIMIT = 200000;

  localparam int SLOTS  = mqspm_pkg::SLOTS;
  localparam int QUEUES = mqspm_pkg::QUEUES;
  localparam int LW     = mqspm_pkg::LW;
  localparam int IN_SW  = mqspm_pkg::IN_SW;
  localparam int IN_QW  = mqspm_pkg::IN_QW;
  localparam int OUT_SW = mqspm_pkg::OUT_SW;
  localparam logic [LW-1:0] NIL = mqspm_pkg::NIL;

  typedef struct packed {
    mqspm_pkg::status_e status;
    logic [OUT_SW-1:0]  slot;
    logic               oldest_valid;
    logic [OUT_SW-1:0]  oldest_slot;
  } pool_word_t;

  typedef enum int {PICK_ANY, PICK_OPEN, PICK_QUEUED} pick_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start_i = 1'b0;
  logic [1:0]        cmd_i = mqspm_pkg::CMD_ALLOC;
  logic [IN_SW-1:0]  slot_index_i = '0;
  logic [IN_QW-1:0]  queue_index_i = '0;
  logic              busy_o;
  logic              done_o;
  logic [1:0]        status_o;
  logic [OUT_SW-1:0] result_slot_o;
  logic              oldest_valid_o;
  logic [OUT_SW-1:0] oldest_slot_o;

  multi_queue_slot_pool_manager_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .cmd_i          (cmd_i),
    .slot_index_i   (slot_index_i),
    .queue_index_i  (queue_index_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .result_slot_o  (result_slot_o),
    .oldest_valid_o (oldest_valid_o),
    .oldest_slot_o  (oldest_slot_o)
  );

  always #5 clk_i = ~clk_i;

  // shadow of the slot pool
  logic [LW-1:0] gl_next [SLOTS];
  logic [LW-1:0] gl_prev [SLOTS];
  logic [LW-1:0] qu_next [SLOTS];
  logic [LW-1:0] qu_prev [SLOTS];
  bit            own_alc [SLOTS];
  bit            own_cmt [SLOTS];
  int            own_q   [SLOTS];
  logic [LW-1:0] qu_head [QUEUES];
  logic [LW-1:0] qu_tail [QUEUES];
  logic [LW-1:0] free_head;
  logic [LW-1:0] list_head;
  logic [LW-1:0] list_tail;
  int            live_slots;

  pool_word_t pending_replies[$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         sender_idle_pct = 0;

  function automatic void clear_pool();
    for (int i = 0; i < SLOTS; i++) begin
      gl_next[i] = (i == 0) ? NIL : LW'(i - 1);
      gl_prev[i] = NIL;
      qu_next[i] = NIL;
      qu_prev[i] = NIL;
      own_alc[i] = 1'b0;
      own_cmt[i] = 1'b0;
      own_q[i]   = 0;
    end
    for (int i = 0; i < QUEUES; i++) begin
      qu_head[i] = NIL;
      qu_tail[i] = NIL;
    end
    free_head  = LW'(SLOTS - 1);
    list_head  = NIL;
    list_tail  = NIL;
    live_slots = 0;
  endfunction

  function automatic pool_word_t apply_command(mqspm_pkg::cmd_e c, int s, int q);
    pool_word_t    w;
    logic [LW-1:0] t;
    logic [LW-1:0] pn;
    logic [LW-1:0] nn;
    int            oq;
    w.status = mqspm_pkg::STS_OK;
    w.slot   = '0;
    case (c)
      mqspm_pkg::CMD_ALLOC: begin
        if (free_head == NIL) begin
          w.status = mqspm_pkg::STS_NOFREE;
        end else begin
          t = free_head;
          free_head = gl_next[t];
          gl_next[t] = list_head;
          gl_prev[t] = NIL;
          if (list_head != NIL) gl_prev[list_head] = t;
          list_head = t;
          if (list_tail == NIL) list_tail = t;
          qu_next[t] = NIL;
          qu_prev[t] = NIL;
          own_alc[t] = 1'b1;
          own_cmt[t] = 1'b0;
          own_q[t]   = 0;
          live_slots++;
          w.slot = OUT_SW'(t);
        end
      end
      mqspm_pkg::CMD_COMMIT: begin
        if (s >= SLOTS || q >= QUEUES || !own_alc[s] || own_cmt[s]) begin
          w.status = mqspm_pkg::STS_BADSLOT;
        end else begin
          own_cmt[s] = 1'b1;
          own_q[s]   = q;
          qu_next[s] = qu_head[q];
          qu_prev[s] = NIL;
          if (qu_head[q] != NIL) qu_prev[qu_head[q]] = LW'(s);
          qu_head[q] = LW'(s);
          if (qu_tail[q] == NIL) qu_tail[q] = LW'(s);
        end
      end
      mqspm_pkg::CMD_PEEK: begin
        if (q >= QUEUES || qu_tail[q] == NIL) w.status = mqspm_pkg::STS_QEMPTY;
        else w.slot = OUT_SW'(qu_tail[q]);
      end
      default: begin
        if (s >= SLOTS || !own_alc[s]) begin
          w.status = mqspm_pkg::STS_BADSLOT;
        end else begin
          if (own_cmt[s]) begin
            oq = own_q[s];
            pn = qu_prev[s];
            nn = qu_next[s];
            if (pn != NIL) qu_next[pn] = nn;
            if (nn != NIL) qu_prev[nn] = pn;
            if (oq < QUEUES) begin
              if (qu_head[oq] == LW'(s)) qu_head[oq] = nn;
              if (qu_tail[oq] == LW'(s)) qu_tail[oq] = pn;
            end
          end
          pn = gl_prev[s];
          nn = gl_next[s];
          if (pn != NIL) gl_next[pn] = nn;
          if (nn != NIL) gl_prev[nn] = pn;
          if (list_head == LW'(s)) list_head = nn;
          if (list_tail == LW'(s)) list_tail = pn;
          qu_next[s] = NIL;
          qu_prev[s] = NIL;
          gl_prev[s] = NIL;
          gl_next[s] = free_head;
          free_head  = LW'(s);
          own_alc[s] = 1'b0;
          own_cmt[s] = 1'b0;
          own_q[s]   = 0;
          live_slots--;
        end
      end
    endcase
    w.oldest_valid = (list_tail != NIL);
    w.oldest_slot  = (list_tail != NIL) ? OUT_SW'(list_tail) : '0;
    return w;
  endfunction

  function automatic int pick_slot(pick_e want);
    int base;
    int s;
    base = $urandom_range(SLOTS - 1);
    for (int i = 0; i < SLOTS; i++) begin
      s = (base + i) % SLOTS;
      if (own_alc[s] && (want == PICK_ANY || (want == PICK_OPEN && !own_cmt[s]) ||
                         (want == PICK_QUEUED && own_cmt[s]))) return s;
    end
    return $urandom_range(SLOTS - 1);
  endfunction

  function automatic int choose_queue();
    if ($urandom_range(3) != 0) return $urandom_range(3);
    return $urandom_range(QUEUES - 1);
  endfunction

  task automatic flag_mismatch(string msg);
    error_count++;
    $display("mismatch at %0t: %s", $realtime, msg);
  endtask

  // start stays high between back-to-back words; it drops only for a gap
  task automatic send_word(mqspm_pkg::cmd_e c, int s, int q);
    start_i       <= 1'b1;
    cmd_i         <= c;
    slot_index_i  <= IN_SW'(s);
    queue_index_i <= IN_QW'(q);
    do @(posedge clk_i); while (busy_o);
    pending_replies.push_back(apply_command(c, s, q));
    if ($urandom_range(99) < sender_idle_pct) begin
      start_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
  endtask

  always @(posedge clk_i) begin
    pool_word_t want;
    if (rst_ni && done_o) begin
      if (pending_replies.size() == 0) begin
        flag_mismatch("word with none expected");
      end else begin
        want = pending_replies.pop_front();
        if (status_o != want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (result_slot_o != want.slot)
          flag_mismatch($sformatf("result_slot %0d, expected %0d", result_slot_o, want.slot));
        if (oldest_valid_o != want.oldest_valid)
          flag_mismatch($sformatf("oldest_valid %0d, expected %0d",
                                  oldest_valid_o, want.oldest_valid));
        if (oldest_slot_o != want.oldest_slot)
          flag_mismatch($sformatf("oldest_slot %0d, expected %0d",
                                  oldest_slot_o, want.oldest_slot));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL multi_queue_slot_pool_manager_core");
      $finish;
    end
  end

  task automatic test_directed_cases();
    send_word(mqspm_pkg::CMD_PEEK, 0, 0);
    send_word(mqspm_pkg::CMD_PEEK, 0, QUEUES - 1);
    send_word(mqspm_pkg::CMD_FREE, 0, 0);
    send_word(mqspm_pkg::CMD_FREE, SLOTS - 1, 0);
    send_word(mqspm_pkg::CMD_COMMIT, SLOTS - 1, 0);
    send_word(mqspm_pkg::CMD_ALLOC, 0, 0);
    send_word(mqspm_pkg::CMD_ALLOC, 0, 0);
    send_word(mqspm_pkg::CMD_COMMIT, SLOTS - 1, QUEUES - 1);
    send_word(mqspm_pkg::CMD_COMMIT, SLOTS - 1, QUEUES - 1);
    send_word(mqspm_pkg::CMD_COMMIT, SLOTS - 2, 0);
    send_word(mqspm_pkg::CMD_COMMIT, SLOTS - 3, 0);
    send_word(mqspm_pkg::CMD_PEEK, 0, QUEUES - 1);
    send_word(mqspm_pkg::CMD_PEEK, 0, 0);
    send_word(mqspm_pkg::CMD_ALLOC, 0, 0);
    send_word(mqspm_pkg::CMD_COMMIT, SLOTS - 3, 0);
    send_word(mqspm_pkg::CMD_PEEK, 0, 0);
    send_word(mqspm_pkg::CMD_FREE, SLOTS - 2, 0);
    send_word(mqspm_pkg::CMD_PEEK, 0, 0);
    send_word(mqspm_pkg::CMD_ALLOC, 0, 0);
    send_word(mqspm_pkg::CMD_FREE, SLOTS - 4, 0);
    send_word(mqspm_pkg::CMD_FREE, SLOTS - 1, 0);
    send_word(mqspm_pkg::CMD_PEEK, 0, QUEUES - 1);
    send_word(mqspm_pkg::CMD_FREE, SLOTS - 1, 0);
    send_word(mqspm_pkg::CMD_ALLOC, 0, 0);
    send_word(mqspm_pkg::CMD_FREE, SLOTS - 3, 0);
    send_word(mqspm_pkg::CMD_FREE, SLOTS - 1, 0);
  endtask

  task automatic test_pool_exhaustion();
    while (free_head != NIL) begin
      send_word(mqspm_pkg::CMD_ALLOC, $urandom_range(SLOTS - 1), $urandom_range(QUEUES - 1));
      if ($urandom_range(7) == 0)
        send_word(mqspm_pkg::CMD_COMMIT, int'(list_head), choose_queue());
      if ($urandom_range(15) == 0) send_word(mqspm_pkg::CMD_PEEK, 0, choose_queue());
    end
    repeat (3) send_word(mqspm_pkg::CMD_ALLOC, 0, 0);
    send_word(mqspm_pkg::CMD_COMMIT, pick_slot(PICK_OPEN), QUEUES - 1);
    repeat (32) begin
      send_word(mqspm_pkg::CMD_FREE, pick_slot(PICK_ANY), $urandom_range(QUEUES - 1));
      if ($urandom_range(7) == 0) send_word(mqspm_pkg::CMD_PEEK, 0, choose_queue());
    end
    send_word(mqspm_pkg::CMD_ALLOC, 0, 0);
  endtask

  task automatic test_random_traffic(int words, int idle_pct);
    int r;
    sender_idle_pct = idle_pct;
    for (int n = 0; n < words; n++) begin
      r = $urandom_range(99);
      if (r < 35 && live_slots > SLOTS - 32) r = 90;
      if (r < 6) begin
        send_word(mqspm_pkg::cmd_e'($urandom_range(3)), $urandom_range(SLOTS - 1),
                  $urandom_range(QUEUES - 1));
      end else if (r < 35) begin
        send_word(mqspm_pkg::CMD_ALLOC, $urandom_range(SLOTS - 1),
                  $urandom_range(QUEUES - 1));
      end else if (r < 60) begin
        send_word(mqspm_pkg::CMD_COMMIT, pick_slot(PICK_OPEN), choose_queue());
      end else if (r < 75) begin
        send_word(mqspm_pkg::CMD_PEEK, $urandom_range(SLOTS - 1), choose_queue());
      end else begin
        send_word(mqspm_pkg::CMD_FREE,
                  pick_slot(($urandom_range(1) == 0) ? PICK_QUEUED : PICK_ANY),
                  $urandom_range(QUEUES - 1));
      end
    end
    sender_idle_pct = 0;
  endtask

  initial begin
    clear_pool();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed_cases();
    test_pool_exhaustion();
    test_random_traffic(30, 0);
    test_random_traffic(30, 87);
    test_random_traffic(30, 21);
    start_i <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS multi_queue_slot_pool_manager_core");
    end else begin
      $display("FAIL multi_queue_slot_pool_manager_core");
    end
    $finish;
  end

endmodule
